### design/uer_pkg.sv
// Shared types and constants for the ultrasonic echo ranger.
// Used by uer_cfg, uer_front, uer_back and the top level; depends on nothing.
`timescale 1ns / 1ps

package uer_pkg;

    // Field widths of the result distance, the measured width and the configuration port.
    localparam int DIST_W     = 11;
    localparam int WIDTH_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

    // Register values after reset.
    localparam logic [7:0]  PERIOD_RST  = 8'd15;
    localparam logic [7:0]  TRIGGER_RST = 8'd11;
    localparam logic [15:0] TIMEOUT_RST = 16'd60000;

    // The distance is width * 34 / 2000 = width * 17 / 1000. The divide by 1000
    // is a multiply by ceil(2^31 / 1000) = 2147484 and a shift by 31, which is
    // exact for every dividend below 2^21. The factor 17 is folded in.
    localparam int              DIST_SHIFT = 31;
    localparam int              MUL_W      = 26;
    localparam logic [MUL_W-1:0] DIST_MUL  = 26'd36507228;
    localparam int              PROD_W     = WIDTH_W + MUL_W;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_TRIG = 2'd1,
        PH_WAIT = 2'd2,
        PH_MEAS = 2'd3
    } phase_t;

    // What an item does to the held distance.
    typedef enum logic [1:0] {
        DIST_KEEP  = 2'd0,
        DIST_LOAD  = 2'd1,
        DIST_CLEAR = 2'd2
    } dist_op_t;

    typedef struct packed {
        logic echo_level;
        logic slow_tick;
    } in_t;

    typedef struct packed {
        logic              trigger_level;
        logic [1:0]        phase;
        logic [DIST_W-1:0] range_cm;
        logic              done_res;
        logic              timed_out;
    } res_t;

    typedef struct packed {
        logic [7:0]  period_ticks;
        logic [7:0]  trigger_us;
        logic [15:0] timeout_us;
    } cfg_t;

    // Result of the sequencer stage, on its way to the distance multiplier.
    typedef struct packed {
        phase_t             phase;
        logic               done_res;
        logic               timed_out;
        dist_op_t           op;
        logic [WIDTH_W-1:0] width;
    } seq_t;

    // Result after the multiplier stage.
    typedef struct packed {
        phase_t            phase;
        logic              done_res;
        logic              timed_out;
        dist_op_t          op;
        logic [PROD_W-1:0] prod;
    } mul_t;

endpackage

### design/uer_cfg.sv
// Configuration registers of the ultrasonic echo ranger.
// Depends on uer_pkg for the register indexes, reset values and cfg_t.
`timescale 1ns / 1ps

module uer_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [uer_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]   cfg_data,
    output uer_pkg::cfg_t                    cfg
);

    uer_pkg::cfg_t cfg_reg;
    uer_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                uer_pkg::CFG_PERIOD:  cfg_next.period_ticks = cfg_data[7:0];
                uer_pkg::CFG_TRIGGER: cfg_next.trigger_us   = cfg_data[7:0];
                uer_pkg::CFG_TIMEOUT: cfg_next.timeout_us   = cfg_data[15:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period_ticks <= uer_pkg::PERIOD_RST;
            cfg_reg.trigger_us   <= uer_pkg::TRIGGER_RST;
            cfg_reg.timeout_us   <= uer_pkg::TIMEOUT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### design/uer_front.sv
// Front end of the ultrasonic echo ranger: takes item transfers and queues them
// for the sequencer. Depends on uer_pkg for in_t.
`timescale 1ns / 1ps

module uer_front
#(
    parameter int DEPTH = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          item_valid,
    output logic          item_stall,
    input  uer_pkg::in_t  item,
    output logic          q_valid,
    input  logic          q_pop,
    output uer_pkg::in_t  q_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    uer_pkg::in_t     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             push;
    logic             pop;

    assign item_stall = (cnt_reg == FULL_CNT);
    assign push       = item_valid && !item_stall;
    assign q_valid    = (cnt_reg != '0);
    assign pop        = q_pop && q_valid;
    assign q_item     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

### design/uer_back.sv
// Back end of the ultrasonic echo ranger: the measurement sequencer, the
// distance multiplier stage and the result register. Depends on uer_pkg.
`timescale 1ns / 1ps

module uer_back
#(
    parameter int COUNTER_BITS = 16
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  uer_pkg::cfg_t  cfg,
    input  logic           q_valid,
    output logic           q_pop,
    input  uer_pkg::in_t   q_item,
    output logic           res_valid,
    input  logic           res_stall,
    output uer_pkg::res_t  res
);

    localparam int CMP_W = (COUNTER_BITS > uer_pkg::WIDTH_W) ? COUNTER_BITS
                                                              : uer_pkg::WIDTH_W;
    localparam logic [COUNTER_BITS-1:0]     CNT_MAX   = '1;
    localparam logic [uer_pkg::WIDTH_W-1:0] WIDTH_MAX = '1;

    uer_pkg::phase_t         phase_reg;
    uer_pkg::phase_t         phase_next;
    logic [7:0]              tick_count_reg;
    logic [7:0]              tick_count_next;
    logic [COUNTER_BITS-1:0] us_count_reg;
    logic [COUNTER_BITS-1:0] us_count_next;

    logic                    advance;
    logic                    pop;
    logic [COUNTER_BITS-1:0] us_inc;
    logic [CMP_W-1:0]        us_ext;
    logic                    count_fail;
    logic [7:0]              trig_len;
    logic                    trig_end;
    logic [7:0]              tick_inc;
    logic                    start;
    logic [uer_pkg::WIDTH_W-1:0] width_sat;
    logic                    done;
    logic                    fail;
    uer_pkg::dist_op_t       op;

    logic                    s1_valid_reg;
    uer_pkg::seq_t           s1_reg;
    uer_pkg::seq_t           s1_next;
    logic                    s2_valid_reg;
    uer_pkg::mul_t           s2_reg;
    uer_pkg::mul_t           s2_next;
    logic                    res_valid_reg;
    uer_pkg::res_t           res_reg;
    uer_pkg::res_t           res_next;

    // The whole back end moves together whenever the result register is free.
    assign advance   = !(res_valid_reg && res_stall);
    assign pop       = advance && q_valid;
    assign q_pop     = advance;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Saturating microsecond count and the timeout test on the counted value.
    assign us_inc     = (us_count_reg != CNT_MAX) ? us_count_reg + COUNTER_BITS'(1)
                                                  : us_count_reg;
    assign count_fail = (CMP_W'(us_inc) > CMP_W'(cfg.timeout_us)) || (us_inc == CNT_MAX);
    assign trig_len   = (cfg.trigger_us == 8'd0) ? 8'd1 : cfg.trigger_us;
    assign trig_end   = (us_inc >= COUNTER_BITS'(trig_len));
    assign tick_inc   = tick_count_reg + 8'd1;
    assign start      = q_item.slow_tick && (tick_inc >= cfg.period_ticks);
    assign us_ext     = CMP_W'(us_count_reg);
    assign width_sat  = (us_ext > CMP_W'(WIDTH_MAX)) ? WIDTH_MAX
                                                     : us_ext[uer_pkg::WIDTH_W-1:0];

    // Next state of the sequencer.
    always_comb
    begin
        phase_next      = phase_reg;
        tick_count_next = tick_count_reg;
        us_count_next   = us_count_reg;
        if (pop)
        begin
            case (phase_reg)
                uer_pkg::PH_IDLE:
                begin
                    if (q_item.slow_tick)
                    begin
                        tick_count_next = tick_inc;
                        if (start)
                        begin
                            tick_count_next = '0;
                            phase_next      = uer_pkg::PH_TRIG;
                            us_count_next   = '0;
                        end
                    end
                end
                uer_pkg::PH_TRIG:
                begin
                    us_count_next = us_inc;
                    if (trig_end)
                    begin
                        phase_next    = uer_pkg::PH_WAIT;
                        us_count_next = '0;
                    end
                end
                uer_pkg::PH_WAIT:
                begin
                    if (q_item.echo_level)
                    begin
                        phase_next    = uer_pkg::PH_MEAS;
                        us_count_next = '0;
                    end
                    else if (count_fail)
                    begin
                        phase_next    = uer_pkg::PH_IDLE;
                        us_count_next = '0;
                    end
                    else
                    begin
                        us_count_next = us_inc;
                    end
                end
                uer_pkg::PH_MEAS:
                begin
                    if (!q_item.echo_level || count_fail)
                    begin
                        phase_next    = uer_pkg::PH_IDLE;
                        us_count_next = '0;
                    end
                    else
                    begin
                        us_count_next = us_inc;
                    end
                end
                default:
                begin
                    phase_next = uer_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // Outputs of the sequencer for the item being taken.
    always_comb
    begin
        done = 1'b0;
        fail = 1'b0;
        op   = uer_pkg::DIST_KEEP;
        case (phase_reg)
            uer_pkg::PH_WAIT:
            begin
                if (!q_item.echo_level && count_fail)
                begin
                    done = 1'b1;
                    fail = 1'b1;
                    op   = uer_pkg::DIST_CLEAR;
                end
            end
            uer_pkg::PH_MEAS:
            begin
                if (!q_item.echo_level)
                begin
                    done = 1'b1;
                    op   = uer_pkg::DIST_LOAD;
                end
                else if (count_fail)
                begin
                    done = 1'b1;
                    fail = 1'b1;
                    op   = uer_pkg::DIST_CLEAR;
                end
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        s1_next.phase     = phase_next;
        s1_next.done_res  = done;
        s1_next.timed_out = fail;
        s1_next.op        = op;
        s1_next.width     = width_sat;

        s2_next.phase     = s1_reg.phase;
        s2_next.done_res  = s1_reg.done_res;
        s2_next.timed_out = s1_reg.timed_out;
        s2_next.op        = s1_reg.op;
        s2_next.prod      = uer_pkg::PROD_W'(s1_reg.width) * uer_pkg::PROD_W'(uer_pkg::DIST_MUL);

        res_next               = res_reg;
        res_next.trigger_level = (s2_reg.phase == uer_pkg::PH_TRIG);
        res_next.phase         = s2_reg.phase;
        res_next.done_res      = s2_reg.done_res;
        res_next.timed_out     = s2_reg.timed_out;
        case (s2_reg.op)
            uer_pkg::DIST_LOAD:
                res_next.range_cm = s2_reg.prod[uer_pkg::DIST_SHIFT +: uer_pkg::DIST_W];
            uer_pkg::DIST_CLEAR:
                res_next.range_cm = '0;
            default:
                res_next.range_cm = res_reg.range_cm;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= uer_pkg::PH_IDLE;
            tick_count_reg <= '0;
            us_count_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
            res_reg        <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            tick_count_reg <= tick_count_next;
            us_count_reg   <= us_count_next;
            if (advance)
            begin
                s1_valid_reg  <= q_valid;
                s2_valid_reg  <= s1_valid_reg;
                res_valid_reg <= s2_valid_reg;
                // The result register also holds the last distance, so it only
                // changes when a real item lands in it.
                if (s2_valid_reg)
                begin
                    res_reg <= res_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_reg <= s1_next;
            s2_reg <= s2_next;
        end
    end

    a_timeout_is_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.timed_out |-> res_reg.done_res)
        else $error("timed_out result without done_res");

    a_timeout_clears_distance: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.timed_out |-> res_reg.range_cm == '0)
        else $error("timed out attempt left a distance");

    a_done_is_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && res_reg.done_res |->
            res_reg.phase == uer_pkg::PH_IDLE && !res_reg.trigger_level)
        else $error("finished attempt not back in idle");

    a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == uer_pkg::PH_IDLE |-> us_count_reg == '0)
        else $error("microsecond count not cleared in idle");

endmodule

### design/ultrasonic_echo_ranger.sv
// Top level of the ultrasonic echo ranger: configuration registers, item queue
// and measurement back end. Depends on uer_pkg, uer_cfg, uer_front, uer_back.
`timescale 1ns / 1ps

// One item transfer per microsecond carries the echo pin sample and the slow
// scheduling tick; every item gives exactly one result transfer showing the
// trigger drive, phase, last distance and done/timeout flags after that item.
// The block takes one item per clock while the result side does not stall;
// the sequencer's registered phase and counter update is the loop that sets
// this rate. A result passes the sequencer, distance multiplier and result
// register after its item leaves the input queue, and the QUEUE_DEPTH-entry
// queue lets the input side keep going for that many items while results stall.
// Configuration writes are always ready and should be made while idle.
module ultrasonic_echo_ranger
#(
    parameter int COUNTER_BITS = 16,
    parameter int QUEUE_DEPTH  = 4
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  uer_pkg::in_t                    item,
    output logic                            res_valid,
    input  logic                            res_stall,
    output uer_pkg::res_t                   res,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [uer_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]  cfg_data
);

    uer_pkg::cfg_t cfg;
    logic          q_valid;
    logic          q_pop;
    uer_pkg::in_t  q_item;

    uer_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    uer_front #(.DEPTH(QUEUE_DEPTH)) u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_item     (q_item)
    );

    uer_back #(.COUNTER_BITS(COUNTER_BITS)) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule
